### rtl/core/lrl_pkg.sv
// Shared types and constants for the LRU replacement list.
package lrl_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int STORE_BITS = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_VICTIM = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;

  typedef logic [STORE_BITS-1:0] lrl_key_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
  } lrl_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] victim_key;
    logic [4:0]  occupancy;
    logic        overflow;
  } lrl_rsp_t;

  typedef struct packed {
    logic from_left;
    logic from_right;
    logic drop;
  } lrl_cell_cmd_t;

endpackage

### rtl/core/lru_replacement_list_top.sv
// Top level of the LRU replacement list: a chain of key cells and its sequencer.
// A transaction is accepted while the block is idle and passes through the states COMPARE
// and UPDATE before its result is registered: in COMPARE every cell compares its key and
// registers a match, and in UPDATE every cell loads from its left or right neighbor, clears
// its valid bit or holds, so that the chain stays ordered most recently used first. Requests
// are taken one at a time; a waiting result does not block acceptance of the next request,
// but the update step waits until the result register is free. A new key offered to a full
// set is refused with overflow set.
module lru_replacement_list_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lrl_pkg::lrl_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lrl_pkg::lrl_rsp_t rsp
);
  import lrl_pkg::*;

  lrl_key_t                      op_key;
  logic                          cmp_en;
  lrl_cell_cmd_t [CAPACITY-1:0]  cmd;
  lrl_key_t                      cell_key [CAPACITY];
  logic [CAPACITY-1:0]           cell_valid;
  logic [CAPACITY-1:0]           hit_vec;
  logic [CAPACITY-1:0]           tail_vec;
  lrl_key_t                      tail_key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lrl_key_t left_key;
    logic     left_valid;
    lrl_key_t right_key;
    logic     right_valid;

    if (i == 0) begin : g_head
      assign left_key   = op_key;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_key   = cell_key[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key   = cell_key[i];
      assign right_valid = 1'b0;
      assign tail_vec[i] = cell_valid[i];
    end else begin : g_mid_r
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
      assign tail_vec[i] = cell_valid[i] && !cell_valid[i+1];
    end

    lrl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmp_en      (cmp_en),
      .probe_key   (op_key),
      .cmd         (cmd[i]),
      .left_key    (left_key),
      .left_valid  (left_valid),
      .right_key   (right_key),
      .right_valid (right_valid),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .hit         (hit_vec[i])
    );
  end

  always_comb begin
    tail_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_vec[i]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  lrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .hit_vec   (hit_vec),
    .tail_vec  (tail_vec),
    .tail_key  (tail_key),
    .cmp_en    (cmp_en),
    .op_key    (op_key),
    .cmd       (cmd)
  );

endmodule

### rtl/core/lrl_cell.sv
// One slot of the recency chain: a key, its valid bit and a registered match flag.
module lrl_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmp_en,
  input  lrl_pkg::lrl_key_t     probe_key,
  input  lrl_pkg::lrl_cell_cmd_t cmd,
  input  lrl_pkg::lrl_key_t     left_key,
  input  logic                  left_valid,
  input  lrl_pkg::lrl_key_t     right_key,
  input  logic                  right_valid,
  output lrl_pkg::lrl_key_t     key,
  output logic                  valid,
  output logic                  hit
);
  import lrl_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.from_left) begin
      key <= left_key;
    end else if (cmd.from_right) begin
      key <= right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (cmd.from_left) begin
        valid <= left_valid;
      end else if (cmd.from_right) begin
        valid <= right_valid;
      end else if (cmd.drop) begin
        valid <= 1'b0;
      end
      if (cmp_en) begin
        hit <= valid && (key == probe_key);
      end
    end
  end

endmodule

### rtl/core/lrl_ctrl.sv
// Sequencer for the recency chain: takes a transaction, steers the cells, forms the result.
module lrl_ctrl (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     req_valid,
  output logic                                     req_stall,
  input  lrl_pkg::lrl_req_t                        req,
  output logic                                     rsp_valid,
  input  logic                                     rsp_stall,
  output lrl_pkg::lrl_rsp_t                        rsp,
  input  logic [lrl_pkg::CAPACITY-1:0]             hit_vec,
  input  logic [lrl_pkg::CAPACITY-1:0]             tail_vec,
  input  lrl_pkg::lrl_key_t                        tail_key,
  output logic                                     cmp_en,
  output lrl_pkg::lrl_key_t                        op_key,
  output lrl_pkg::lrl_cell_cmd_t [lrl_pkg::CAPACITY-1:0] cmd
);
  import lrl_pkg::*;

  typedef enum logic [1:0] {IDLE, COMPARE, UPDATE} state_t;

  state_t           state;
  logic [1:0]       op_mode;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             present;
  logic             full;
  logic             fire;
  logic             ok_next;
  logic             overflow_next;
  logic [31:0]      victim_next;

  assign req_stall = (state != IDLE);
  assign cmp_en    = (state == COMPARE);
  assign present   = |hit_vec;
  assign full      = (count == CNT_W'(CAPACITY));
  assign fire      = (state == UPDATE) && !(rsp_valid && rsp_stall);

  always_comb begin
    cmd           = '0;
    ok_next       = 1'b0;
    overflow_next = 1'b0;
    victim_next   = '0;
    count_next    = count;
    case (op_mode)
      MODE_INSERT: begin
        if (present) begin
          ok_next = 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i].from_left = fire && (|(hit_vec >> i));
          end
        end else if (full) begin
          overflow_next = 1'b1;
        end else begin
          ok_next    = 1'b1;
          count_next = count + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i].from_left = fire;
          end
        end
      end
      MODE_VICTIM: begin
        if (count != '0) begin
          ok_next     = 1'b1;
          victim_next = 32'(tail_key);
          count_next  = count - CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i].drop = fire && tail_vec[i];
          end
        end
      end
      MODE_ERASE: begin
        if (present) begin
          ok_next    = 1'b1;
          count_next = count - CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i].from_right = fire && (|(hit_vec << (CAPACITY - 1 - i)));
          end
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !fire) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            op_mode <= req.mode;
            op_key  <= req.key[STORE_BITS-1:0];
            state   <= COMPARE;
          end
        end
        COMPARE: begin
          state <= UPDATE;
        end
        UPDATE: begin
          if (fire) begin
            count              <= count_next;
            rsp.ok             <= ok_next;
            rsp.victim_key     <= victim_next;
            rsp.occupancy      <= 5'(count_next);
            rsp.overflow       <= overflow_next;
            rsp_valid          <= 1'b1;
            state              <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/lrl_checker.sv
// Port-level checks for the LRU replacement list, bound to the top level.
module lrl_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input lrl_pkg::lrl_req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input lrl_pkg::lrl_rsp_t rsp
);
  import lrl_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled result transaction changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Request accepted while the previous transaction was in progress.");

  a_overflow_not_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> !rsp.ok && rsp.occupancy == 5'(CAPACITY))
    else $error("Overflow reported with ok set or with the set not full.");

  a_victim_needs_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.victim_key != '0 |-> rsp.ok && !rsp.overflow)
    else $error("Nonzero victim key on a failed transaction.");

endmodule

bind lru_replacement_list_top lrl_checker u_lrl_checker (.*);
